[sv/radix_converter_macros.svh]
// assertion macros shared by the radix converter rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef RADIX_CONVERTER_MACROS_SVH
`define RADIX_CONVERTER_MACROS_SVH

// checked only while out of reset
`define RC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define RC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/rc_pkg.sv]
// radix converter package: widths, codes, fsm states, control structs
// and the character decode and encode functions; no dependencies
package rc_pkg;

  localparam int unsigned RC_VALUE_WIDTH = 32;
  localparam int unsigned RC_MAX_DIGITS  = 32;
  localparam int unsigned RC_BUF_CAP     = 32;

  localparam int unsigned SB_W   = 5;
  localparam int unsigned TB_W   = 6;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ERR_W  = 3;
  localparam int unsigned CFG_W  = 6;
  localparam int unsigned DIG_W  = 5;
  localparam int unsigned REM_W  = 4;

  localparam logic [SB_W-1:0] SB_RESET = SB_W'(10);
  localparam logic [TB_W-1:0] TB_RESET = TB_W'(2);

  localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
  localparam logic [CHAR_W-1:0] CH_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_F = 8'h46;
  localparam logic [DIG_W-1:0]  DIG_BAD = DIG_W'(16);

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 3'd0,
    ERR_DIGIT = 3'd1,
    ERR_OVF   = 3'd2,
    ERR_BASE  = 3'd3,
    ERR_REM   = 3'd4
  } err_e;

  typedef enum logic {
    CFG_SRC_BASE = 1'b0,
    CFG_TGT_BASE = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV,
    S_STORE,
    S_EMIT,
    S_ERR
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic clr;
    logic div_start;
    logic div_step;
    logic dig_zero;
    logic dig_store;
    logic emit_load;
    logic err_load;
    err_e err_code;
  } cmd_t;

  typedef struct packed {
    logic flag_digit;
    logic flag_ovf;
    logic tb_low;
    logic acc_zero;
    logic div_last;
    logic rem_big;
    logic cnt_full;
    logic cnt_one;
    logic out_free;
  } sts_t;

  function automatic logic [DIG_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
    logic [DIG_W-1:0] d;
    if (c >= CH_0 && c <= CH_9) begin
      d = DIG_W'(c - CH_0);
    end else if (c >= CH_A && c <= CH_F) begin
      d = DIG_W'(c - CH_A) + DIG_W'(10);
    end else begin
      d = DIG_BAD;
    end
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] encode_digit(input logic [REM_W-1:0] r);
    logic [CHAR_W-1:0] c;
    if (r < REM_W'(10)) begin
      c = CH_0 + CHAR_W'(r);
    end else begin
      c = CH_A + CHAR_W'(r - REM_W'(10));
    end
    return c;
  endfunction

endpackage

[sv/radix_converter.sv]
// channel | dir | signals                    | payload
// s_axis  | in  | tvalid tready tdata tlast  | tdata: digit_char[7:0]; tlast: last_digit
// m_axis  | out | tvalid tready tdata tuser tlast | tdata: out_char[7:0]; tuser: error_code[2:0]
// cfg     | in  | cfg_we_i cfg_idx_i cfg_wdata_i | 0 source_base, 1 target_base
// one digit transfer per cycle is taken in idle; a last digit then goes to S_DECIDE
// each output digit comes from the bit-serial divider, then one result transfer per cycle
// while m_axis_tready is high; the next number is taken once the last result is loaded
// the output register holds a result while m_axis_tready is low and stalls the emitter
// reset (rst_ni, async low) sets source_base 10, target_base 2 and clears the number
// top level of the radix converter; depends on rc_pkg, rc_ctrl, rc_datapath

module radix_converter #(
  parameter int unsigned VALUE_WIDTH = rc_pkg::RC_VALUE_WIDTH,
  parameter int unsigned MAX_DIGITS  = rc_pkg::RC_MAX_DIGITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  rc_pkg::cfg_e               cfg_idx_i,
  input  logic [rc_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [rc_pkg::CHAR_W-1:0]  s_axis_tdata,   // [7:0] digit_char
  input  logic                       s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [rc_pkg::CHAR_W-1:0]  m_axis_tdata,   // [7:0] out_char
  output logic [rc_pkg::ERR_W-1:0]   m_axis_tuser,   // [2:0] error_code
  output logic                       m_axis_tlast
);
  import rc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  rc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_char_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule

[sv/rc_ctrl.sv]
// radix converter controller: sequences accumulate, divide, store and emit
// depends on rc_pkg and radix_converter_macros.svh
`include "radix_converter_macros.svh"

module rc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_last_i,
  output logic          s_ready_o,
  input  rc_pkg::sts_t  sts_i,
  output rc_pkg::cmd_t  cmd_o
);
  import rc_pkg::*;

  state_e state_q, state_d;
  err_e   err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      err_q   <= ERR_NONE;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i && s_last_i) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (sts_i.flag_digit) begin
          err_d = ERR_DIGIT; state_d = S_ERR;
        end else if (sts_i.flag_ovf) begin
          err_d = ERR_OVF; state_d = S_ERR;
        end else if (sts_i.tb_low) begin
          err_d = ERR_BASE; state_d = S_ERR;
        end else if (sts_i.acc_zero) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_STORE;
      end
      S_STORE: begin
        priority if (sts_i.rem_big) begin
          err_d = ERR_REM; state_d = S_ERR;
        end else if (sts_i.cnt_full) begin
          err_d = ERR_OVF; state_d = S_ERR;
        end else if (sts_i.acc_zero) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_DIV;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free && sts_i.cnt_one) state_d = S_IDLE;
      end
      S_ERR: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.err_code = err_q;
    s_ready_o      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.acc_en = s_valid_i;
      end
      S_DECIDE: begin
        if (!sts_i.flag_digit && !sts_i.flag_ovf && !sts_i.tb_low) begin
          cmd_o.dig_zero  = sts_i.acc_zero;
          cmd_o.div_start = !sts_i.acc_zero;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      S_STORE: begin
        if (!sts_i.rem_big && !sts_i.cnt_full) begin
          cmd_o.dig_store = 1'b1;
          cmd_o.div_start = !sts_i.acc_zero;
        end
      end
      S_EMIT: begin
        cmd_o.emit_load = sts_i.out_free;
        cmd_o.clr       = sts_i.out_free && sts_i.cnt_one;
      end
      S_ERR: begin
        cmd_o.err_load = sts_i.out_free;
        cmd_o.clr      = sts_i.out_free;
      end
      default: ;
    endcase
  end

  `RC_ASSERT(a_store_after_div, (state_q == S_STORE) |-> $past(state_q == S_DIV), "store without division")
  `RC_ASSERT(a_err_has_code, cmd_o.err_load |-> (err_q != ERR_NONE), "error transfer without code")

endmodule

[sv/rc_datapath.sv]
// radix converter datapath: config registers, accumulator, bit-serial divider,
// remainder buffer and output register; depends on rc_pkg and the macro header
`include "radix_converter_macros.svh"

module rc_datapath #(
  parameter int unsigned VALUE_WIDTH = rc_pkg::RC_VALUE_WIDTH,
  parameter int unsigned MAX_DIGITS  = rc_pkg::RC_MAX_DIGITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  rc_pkg::cfg_e                cfg_idx_i,
  input  logic [rc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic [rc_pkg::CHAR_W-1:0]   in_char_i,
  input  rc_pkg::cmd_t                cmd_i,
  output rc_pkg::sts_t                sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rc_pkg::CHAR_W-1:0]   out_char_o,
  output logic                        out_last_o,
  output logic [rc_pkg::ERR_W-1:0]    out_err_o
);
  import rc_pkg::*;

  localparam int unsigned LIMIT = (MAX_DIGITS < RC_BUF_CAP) ? MAX_DIGITS : RC_BUF_CAP;
  localparam int unsigned AW    = $clog2(LIMIT);
  localparam int unsigned CW    = $clog2(LIMIT + 1);
  localparam int unsigned BW    = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned PW    = VALUE_WIDTH + SB_W;

  logic [SB_W-1:0]        sb_q;
  logic [TB_W-1:0]        tb_q;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [1:0]             flags_q, flags_d;
  logic [TB_W-1:0]        rem_q, rem_d;
  logic [BW-1:0]          bcnt_q, bcnt_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [REM_W-1:0]       buf_q [LIMIT];

  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      out_char_q;
  logic                   out_last_q;
  err_e                   out_err_q;

  logic [DIG_W-1:0]       dig;
  logic [PW-1:0]          prod;
  logic [TB_W:0]          trial;
  logic                   ge;
  logic [CW-1:0]          cnt_m1;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q <= SB_RESET;
      tb_q <= TB_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_BASE: sb_q <= cfg_wdata_i[SB_W-1:0];
        CFG_TGT_BASE: tb_q <= cfg_wdata_i[TB_W-1:0];
        default: ;
      endcase
    end
  end

  assign dig   = decode_char(in_char_i);
  assign prod  = ({{SB_W{1'b0}}, acc_q} * PW'(sb_q)) + PW'(dig);
  assign trial = {rem_q, acc_q[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, tb_q};
  assign cnt_m1 = cnt_q - CW'(1);

  always_comb begin
    acc_d   = acc_q;
    flags_d = flags_q;
    rem_d   = rem_q;
    bcnt_d  = bcnt_q;
    cnt_d   = cnt_q;
    if (cmd_i.clr) begin
      acc_d   = '0;
      flags_d = '0;
      cnt_d   = '0;
    end else begin
      if (cmd_i.acc_en && flags_q == 2'b00) begin
        priority if (dig >= DIG_W'(sb_q)) begin
          flags_d = 2'b01;
        end else if (prod[PW-1:VALUE_WIDTH] != '0) begin
          flags_d = 2'b10;
        end else begin
          acc_d = prod[VALUE_WIDTH-1:0];
        end
      end
      if (cmd_i.div_step) begin
        rem_d  = ge ? TB_W'(trial - {1'b0, tb_q}) : trial[TB_W-1:0];
        acc_d  = {acc_q[VALUE_WIDTH-2:0], ge};
        bcnt_d = bcnt_q - BW'(1);
      end
      if (cmd_i.div_start) begin
        rem_d  = '0;
        bcnt_d = BW'(VALUE_WIDTH);
      end
      if (cmd_i.dig_zero)  cnt_d = CW'(1);
      if (cmd_i.dig_store) cnt_d = cnt_q + CW'(1);
      if (cmd_i.emit_load) cnt_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      flags_q <= '0;
      rem_q   <= '0;
      bcnt_q  <= '0;
      cnt_q   <= '0;
    end else begin
      acc_q   <= acc_d;
      flags_q <= flags_d;
      rem_q   <= rem_d;
      bcnt_q  <= bcnt_d;
      cnt_q   <= cnt_d;
    end
  end

  // remainder buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.dig_zero) begin
      buf_q[0] <= '0;
    end else if (cmd_i.dig_store) begin
      buf_q[cnt_q[AW-1:0]] <= rem_q[REM_W-1:0];
    end
  end

  // output register
  assign out_valid_d = cmd_i.emit_load || cmd_i.err_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_char_q <= encode_digit(buf_q[cnt_m1[AW-1:0]]);
      out_last_q <= (cnt_q == CW'(1));
      out_err_q  <= ERR_NONE;
    end else if (cmd_i.err_load) begin
      out_char_q <= '0;
      out_last_q <= 1'b1;
      out_err_q  <= cmd_i.err_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_err_o   = out_err_q;

  assign sts_o.flag_digit = flags_q[0];
  assign sts_o.flag_ovf   = flags_q[1];
  assign sts_o.tb_low     = tb_q < TB_W'(2);
  assign sts_o.acc_zero   = acc_q == '0;
  assign sts_o.div_last   = bcnt_q == BW'(1);
  assign sts_o.rem_big    = rem_q > TB_W'(15);
  assign sts_o.cnt_full   = cnt_q >= CW'(LIMIT);
  assign sts_o.cnt_one    = cnt_q == CW'(1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  `RC_ASSERT(a_emit_has_digit, cmd_i.emit_load |-> (cnt_q != '0), "emit with empty buffer")
  `RC_ASSERT(a_clear_empties, cmd_i.clr |=> (acc_q == '0 && flags_q == 2'b00 && cnt_q == '0), "clear incomplete")

endmodule
